>>> sv/wsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsg_pkg
// Shared constants and types for the five-voice wavetable generator.
// ----------------------------------------------------------------------------
package wsg_pkg;

  localparam int NUM_VOICES   = 5;
  localparam int WAVE_LEN     = 32;
  localparam int RATE_DIVIDER = 16;
  localparam int WAVE_BYTES   = NUM_VOICES * WAVE_LEN;
  localparam int PHASE_W      = 21;
  localparam int PER_W        = 12;
  localparam int DIVS_W       = PER_W + 1;
  localparam int MUL_W        = 25;
  localparam int PROD_W       = 2 * MUL_W;

  // phase step = 2^21 / (period + 1); the rate divider cancels out
  localparam int DIV_STEPS    = PHASE_W + 1;

  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_WWR   = 3'd1;
  localparam logic [2:0] CMD_WRD   = 3'd2;
  localparam logic [2:0] CMD_VOL   = 3'd3;
  localparam logic [2:0] CMD_FREQ  = 3'd4;
  localparam logic [2:0] CMD_KEY   = 3'd5;

  localparam logic [1:0] REG_UPDATE_STEP = 2'd0;
  localparam logic [1:0] REG_GAIN        = 2'd1;
  localparam logic [1:0] REG_SHARE       = 2'd2;

  localparam logic [7:0]  SHARE_LO  = 8'h60;
  localparam logic [7:0]  SHARE_HI  = 8'h80;
  localparam logic [2:0]  LAST_CH   = 3'd4;
  localparam logic [14:0] SAT_MAX   = 15'h7fff;
  localparam logic [3:0]  MIN_PER   = 4'd8;

  // reciprocals: floor(x/5) = (x*209716)>>20 for x < 2^18,
  // floor(x/100) = (x*5368710)>>29 for x < 6e6
  localparam logic [MUL_W-1:0] RECIP5   = 25'd209716;
  localparam logic [MUL_W-1:0] RECIP100 = 25'd5368710;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_MIRROR = 12'b000000000010,
    ST_READ   = 12'b000000000100,
    ST_DIV    = 12'b000000001000,
    ST_SEL    = 12'b000000010000,
    ST_MUL1   = 12'b000000100000,
    ST_MUL2   = 12'b000001000000,
    ST_ACC    = 12'b000010000000,
    ST_MIX1   = 12'b000100000000,
    ST_MIX2   = 12'b001000000000,
    ST_MIX3   = 12'b010000000000,
    ST_OUT    = 12'b100000000000
  } state_t;

endpackage

>>> sv/wsg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 160
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/wsg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsg_div
// Restoring divider: 2^21 / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wsg_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [wsg_pkg::DIVS_W-1:0]  divisor,
  output logic                        done,
  output logic [wsg_pkg::PHASE_W-1:0] quotient
);
  import wsg_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic               run_r, run_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIVS_W-1:0]  d_r, d_nxt;
  logic [DIVS_W-1:0]  rem_r, rem_nxt;
  logic [PHASE_W:0]   q_r, q_nxt;
  logic               done_r, done_nxt;
  logic [DIVS_W:0]    trial;

  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    done_nxt = 1'b0;
    // dividend is a single one at the top bit
    trial    = {rem_r, (cnt_r == CNT_W'(DIV_STEPS - 1))};
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(DIV_STEPS - 1);
      d_nxt   = divisor;
      rem_nxt = '0;
      q_nxt   = '0;
    end else if (run_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = DIVS_W'(trial - {1'b0, d_r});
        q_nxt   = {q_r[PHASE_W-1:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVS_W-1:0];
        q_nxt   = {q_r[PHASE_W-1:0], 1'b0};
      end
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r[PHASE_W-1:0];

endmodule

>>> sv/wavetable_sound_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavetable_sound_generator_core
// Five-voice wavetable generator with bus commands and a tick-driven mixer.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; each beat yields
// exactly one result on out_valid for one cycle, which the receiver must take.
// Volume, key and plain wave writes need no further state; a shared-voice
// wave write also copies the byte into the last voice, and a wave read goes
// through the registered RAM read. An in-range frequency write waits for the
// bit-serial phase-step divider. In a tick, one shared multiplier handles the
// wave times volume, the resampling scale and the output scaling, one product
// per cycle. The wave RAM reads as zero after reset through per-entry valid
// bits, so no clearing pass is needed.
module wavetable_sound_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_addr,
  input  logic [7:0]  in_wdata,
  output logic        out_valid,
  output logic [15:0] out_sample,
  output logic [7:0]  out_read_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import wsg_pkg::*;

  state_t state_r, state_nxt;

  logic [15:0] step_r;
  logic [6:0]  gain_r;
  logic        share_r;

  logic [PHASE_W-1:0] phase_r [NUM_VOICES];
  logic [PHASE_W-1:0] inc_r   [NUM_VOICES];
  logic [3:0]         vol_r   [NUM_VOICES];
  logic [PER_W-1:0]   per_r   [NUM_VOICES];
  logic [7:0]         pbyte_r [2*NUM_VOICES];
  logic [NUM_VOICES-1:0] key_r;
  logic [WAVE_BYTES-1:0] wvalid_r;

  logic [2:0]  ch_r, ch_nxt;
  logic [7:0]  addr_r;
  logic [7:0]  data_r;
  logic [12:0] sum_r, sum_nxt;
  logic        neg_r, neg_nxt;
  logic        rvalid_r, rvalid_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;

  logic        ov_r, ov_nxt;
  logic [15:0] os_r, os_nxt;
  logic [7:0]  ord_r, ord_nxt;

  // RAM port
  logic        ram_we;
  logic [7:0]  ram_waddr, ram_raddr, ram_rdata;

  // divider
  logic               div_start, div_done;
  logic [DIVS_W-1:0]  div_d;
  logic [PHASE_W-1:0] div_q;

  // shared multiplier
  logic signed [MUL_W-1:0] mul_a, mul_b;

  logic [PHASE_W-1:0] new_phase;
  logic               ch_active;
  logic [PER_W-1:0]   new_per;
  logic [11:0]        mag;
  logic [14:0]        v1, v2;
  logic signed [PROD_W-1:0] t_sh;
  logic signed [PROD_W-1:0] c_sh;
  logic               accept;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign new_phase = phase_r[ch_r] + inc_r[ch_r];
  assign ch_active = key_r[ch_r] && (vol_r[ch_r] != 4'd0) &&
                     (per_r[ch_r] > PER_W'(MIN_PER));
  assign mag       = sum_r[12] ? 12'(-sum_r) : sum_r[11:0];
  assign v1        = (prod_r[PROD_W-1:20] > (PROD_W-20)'(SAT_MAX)) ? SAT_MAX
                                                                : prod_r[34:20];
  assign v2        = (prod_r[PROD_W-1:29] > (PROD_W-29)'(SAT_MAX)) ? SAT_MAX
                                                                : prod_r[43:29];
  assign t_sh      = prod_r >>> 3;
  assign c_sh      = prod_r >>> 15;

  // period with the new byte in place
  always_comb begin
    logic [7:0] lo, hi;
    lo = (in_addr[0] == 1'b0) ? in_wdata : pbyte_r[{in_addr[3:1], 1'b0}];
    hi = (in_addr[0] == 1'b1) ? in_wdata : pbyte_r[{in_addr[3:1], 1'b1}];
    new_per = {hi[3:0], lo};
  end

  always_comb begin
    state_nxt  = state_r;
    ch_nxt     = ch_r;
    sum_nxt    = sum_r;
    neg_nxt    = neg_r;
    rvalid_nxt = rvalid_r;
    prod_nxt   = prod_r;
    ov_nxt     = 1'b0;
    os_nxt     = '0;
    ord_nxt    = '0;
    ram_we     = 1'b0;
    ram_waddr  = in_addr;
    ram_raddr  = in_addr;
    div_start  = 1'b0;
    div_d      = DIVS_W'(new_per) + 1'b1;
    mul_a      = '0;
    mul_b      = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_TICK: begin
              ch_nxt    = '0;
              sum_nxt   = '0;
              state_nxt = ST_SEL;
            end
            CMD_WWR: begin
              ov_nxt = 1'b1;
              if (in_addr < 8'(WAVE_BYTES)) begin
                ram_we = 1'b1;
                if (share_r && in_addr >= SHARE_LO && in_addr < SHARE_HI) begin
                  state_nxt = ST_MIRROR;
                end
              end
            end
            CMD_WRD: begin
              rvalid_nxt = (in_addr < 8'(WAVE_BYTES)) && wvalid_r[in_addr];
              state_nxt  = ST_READ;
            end
            CMD_FREQ: begin
              ov_nxt = 1'b1;
              if (in_addr < 8'(2*NUM_VOICES)) begin
                div_start = 1'b1;
                state_nxt = ST_DIV;
              end
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_MIRROR: begin
        ram_we    = 1'b1;
        ram_waddr = {LAST_CH, addr_r[4:0]};
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        ov_nxt    = 1'b1;
        ord_nxt   = rvalid_r ? ram_rdata : 8'd0;
        state_nxt = ST_IDLE;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SEL: begin
        ram_raddr  = {ch_r, new_phase[PHASE_W-1:16]};
        rvalid_nxt = wvalid_r[{ch_r, new_phase[PHASE_W-1:16]}];
        if (ch_active) begin
          state_nxt = ST_MUL1;
        end else if (ch_r == LAST_CH) begin
          state_nxt = ST_MIX1;
        end else begin
          ch_nxt = ch_r + 1'b1;
        end
      end
      ST_MUL1: begin
        mul_a     = MUL_W'(signed'(rvalid_r ? ram_rdata : 8'd0));
        mul_b     = MUL_W'(vol_r[ch_r]);
        prod_nxt  = PROD_W'(mul_a * mul_b);
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        mul_a     = t_sh[MUL_W-1:0];
        mul_b     = MUL_W'(step_r);
        prod_nxt  = PROD_W'(mul_a * mul_b);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        sum_nxt = sum_r + c_sh[12:0];
        if (ch_r == LAST_CH) begin
          state_nxt = ST_MIX1;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = ST_SEL;
        end
      end
      ST_MIX1: begin
        neg_nxt   = sum_r[12];
        mul_a     = MUL_W'({mag, 7'b0});
        mul_b     = RECIP5;
        prod_nxt  = PROD_W'(mul_a * mul_b);
        state_nxt = ST_MIX2;
      end
      ST_MIX2: begin
        mul_a     = MUL_W'(v1);
        mul_b     = MUL_W'(gain_r);
        prod_nxt  = PROD_W'(mul_a * mul_b);
        state_nxt = ST_MIX3;
      end
      ST_MIX3: begin
        mul_a     = prod_r[MUL_W-1:0];
        mul_b     = RECIP100;
        prod_nxt  = PROD_W'(mul_a * mul_b);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        ov_nxt    = 1'b1;
        os_nxt    = neg_r ? 16'(-{1'b0, v2}) : {1'b0, v2};
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      step_r   <= 16'd32768;
      gain_r   <= 7'd100;
      share_r  <= 1'b1;
      key_r    <= '0;
      wvalid_r <= '0;
      ov_r     <= 1'b0;
      for (int i = 0; i < NUM_VOICES; i++) begin
        phase_r[i] <= '0;
        inc_r[i]   <= '0;
        vol_r[i]   <= '0;
        per_r[i]   <= '0;
      end
      for (int i = 0; i < 2*NUM_VOICES; i++) begin
        pbyte_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_UPDATE_STEP: step_r  <= cfg_wdata;
          REG_GAIN:        gain_r  <= cfg_wdata[6:0];
          REG_SHARE:       share_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (ram_we) begin
        wvalid_r[ram_waddr] <= 1'b1;
      end
      if (accept && in_cmd == CMD_VOL && in_addr[2:0] < 3'(NUM_VOICES)) begin
        vol_r[in_addr[2:0]] <= in_wdata[3:0];
      end
      if (accept && in_cmd == CMD_KEY) begin
        key_r <= in_wdata[NUM_VOICES-1:0];
      end
      if (div_start) begin
        pbyte_r[in_addr[3:0]] <= in_wdata;
        per_r[in_addr[3:1]]   <= new_per;
      end
      if (state_r == ST_DIV && div_done) begin
        inc_r[addr_r[3:1]] <= div_q;
      end
      if (state_r == ST_SEL && ch_active) begin
        phase_r[ch_r] <= new_phase;
      end
    end
    if (accept) begin
      addr_r <= in_addr;
      data_r <= in_wdata;
    end
    ch_r     <= ch_nxt;
    sum_r    <= sum_nxt;
    neg_r    <= neg_nxt;
    rvalid_r <= rvalid_nxt;
    prod_r   <= prod_nxt;
    os_r     <= os_nxt;
    ord_r    <= ord_nxt;
  end

  wsg_ram #(
    .WIDTH (8),
    .DEPTH (WAVE_BYTES)
  ) u_wave_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ((state_r == ST_MIRROR) ? data_r : in_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wsg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_valid     = ov_r;
  assign out_sample    = os_r;
  assign out_read_data = ord_r;

endmodule
